@@ design/tabulated_cdf_inverse_sampler_macros.svh @@
// assertion macros for the tabulated cdf inverse sampler
// used by tabulated_cdf_inverse_sampler.sv; no other dependencies
`ifndef TABULATED_CDF_INVERSE_SAMPLER_MACROS_SVH
`define TABULATED_CDF_INVERSE_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// condition holds in the same cycle
`define TCIS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcis implication check failed");
// condition holds in the next cycle
`define TCIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcis next-cycle check failed");
`else
`define TCIS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define TCIS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/tcis_pkg.sv @@
// shared types and constants of the tabulated cdf inverse sampler
// no dependencies
`default_nettype none
package tcis_pkg;

  localparam int GRID_POINTS = 1024;
  localparam int IDX_W = $clog2(GRID_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int CFG_W = 11;
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_POINTS = 3'd0;

  // shared multiply-divide unit
  localparam int MD_W = 33;
  localparam int MD_SW = 6;
  localparam logic [MD_SW-1:0] MD_LAST = 6'd32;

  // action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_PROB = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_END_LO, S_END_HI, S_END_CAP, S_CLAMP, S_PT_START, S_SRCH, S_SRCH_CMP,
    S_FETCH_LO, S_FETCH_HI, S_FETCH_CAP, S_LERP_SET, S_LERP_RUN, S_PASS_END, S_DONE
  } state_t;

  typedef enum logic [1:0] {P_CMIN, P_CMAX, P_BLEND, P_INV} pass_t;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_phase_t;

  typedef struct packed {
    logic start;
    logic [MD_W-1:0] a;
    logic [MD_W-1:0] b;
    logic [MD_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [MD_W-1:0] q;
  } md_rsp_t;

endpackage
`default_nettype wire

@@ design/tcis_in_if.sv @@
// input channel of the sampler: handshake plus request fields
// depends on nothing
`default_nettype none
interface tcis_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [9:0] point_index;
  logic signed [31:0] point_log_mass;
  logic [31:0] point_cumulative;
  logic signed [31:0] min_log_mass;
  logic signed [31:0] max_log_mass;
  logic [31:0] uniform_draw;

  modport source (
    output valid, action, point_index, point_log_mass, point_cumulative,
    output min_log_mass, max_log_mass, uniform_draw,
    input ready
  );
  modport sink (
    input valid, action, point_index, point_log_mass, point_cumulative,
    input min_log_mass, max_log_mass, uniform_draw,
    output ready
  );
endinterface
`default_nettype wire

@@ design/tcis_out_if.sv @@
// output channel of the sampler: handshake plus result fields
// depends on nothing
`default_nettype none
interface tcis_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] sampled_log_mass;
  logic [31:0] range_probability;
  logic [1:0] status;

  modport source (
    output valid, sampled_log_mass, range_probability, status,
    input ready
  );
  modport sink (
    input valid, sampled_log_mass, range_probability, status,
    output ready
  );
endinterface
`default_nettype wire

@@ design/tcis_muldiv.sv @@
// shared iterative unit: floor(a * b / d) with b <= d
// shift-add multiply then restoring divide; uses tcis_pkg
`default_nettype none
module tcis_muldiv import tcis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire md_req_t req,
  output md_rsp_t rsp
);

  md_phase_t phase, phase_next;
  logic [MD_SW-1:0] step, step_next;
  logic [2*MD_W-1:0] acc, acc_next;
  logic [MD_W-1:0] mcand, dvs;
  logic done, done_next;

  logic [MD_W:0] psum;
  logic [MD_W:0] trial;
  logic ge;
  logic [MD_W:0] rem;

  // one multiply step and one divide step
  always_comb begin
    psum = {1'b0, acc[2*MD_W-1:MD_W]} + (acc[0] ? {1'b0, mcand} : '0);
    trial = {acc[2*MD_W-1:MD_W], acc[MD_W-1]};
    ge = trial >= {1'b0, dvs};
    rem = ge ? trial - {1'b0, dvs} : trial;
  end

  // sequencer
  always_comb begin
    phase_next = phase;
    step_next = step;
    acc_next = acc;
    done_next = 1'b0;
    case (phase)
      MD_IDLE: begin
        if (req.start) begin
          phase_next = MD_MUL;
          step_next = '0;
          acc_next = {{MD_W{1'b0}}, req.b};
        end
      end
      MD_MUL: begin
        acc_next = {psum, acc[MD_W-1:1]};
        step_next = step + 1'b1;
        if (step == MD_LAST) begin
          phase_next = MD_DIV;
          step_next = '0;
        end
      end
      MD_DIV: begin
        acc_next = {rem[MD_W-1:0], acc[MD_W-2:0], ge};
        step_next = step + 1'b1;
        if (step == MD_LAST) begin
          phase_next = MD_IDLE;
          done_next = 1'b1;
        end
      end
      default: phase_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MD_IDLE;
      done <= 1'b0;
    end else begin
      phase <= phase_next;
      done <= done_next;
    end
    step <= step_next;
    acc <= acc_next;
    if (phase == MD_IDLE && req.start) begin
      mcand <= req.a;
      dvs <= req.d;
    end
  end

  assign rsp.busy = (phase != MD_IDLE);
  assign rsp.done = done;
  assign rsp.q = acc[MD_W-1:0];

endmodule
`default_nettype wire

@@ design/tabulated_cdf_inverse_sampler.sv @@
// Tabulated cdf inverse sampler. A load item writes one table point (log10 mass Q8.24,
// cumulative Q1.31). A sample or probability item reads both table ends, clamps the
// range, and evaluates the cumulative value at each end with a binary search of about
// eleven probes and an interpolation; a sample then blends with the draw and inverts
// with one more search and interpolation. Every interpolation and the blend run on one
// shared shift-add multiply / restoring divide unit. One item is processed at a time;
// the next is taken once the result sits in the output register. Table entries must
// be loaded before a search reads them.
// depends on tcis_pkg, tcis_in_if, tcis_out_if, tcis_muldiv and the macros header
`default_nettype none
`include "tabulated_cdf_inverse_sampler_macros.svh"
module tabulated_cdf_inverse_sampler import tcis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  tcis_in_if.sink req,
  tcis_out_if.source rsp,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  state_t state, state_next;
  pass_t pass;

  // table memory: log mass in the upper half, cumulative in the lower
  logic [63:0] mem [GRID_POINTS];
  logic [63:0] rd_data;
  logic [IDX_W-1:0] rd_addr;

  logic [CFG_W-1:0] points_in_use;
  logic [CNT_W-1:0] n_act, n_last;

  logic [1:0] act;
  logic signed [31:0] rmin, rmax;
  logic [31:0] udraw;
  logic signed [31:0] lm0, lmn;
  logic [31:0] c0, cn;
  logic signed [31:0] hi_x;
  logic signed [32:0] key;
  logic [CNT_W-1:0] first, cnt;
  logic [IDX_W-1:0] hi_idx;
  logic [63:0] pa, pb;
  logic signed [33:0] val, va_r, cmin, cmax;
  logic up_r;

  logic [31:0] res_sample, res_prob;
  logic [1:0] res_status;
  logic out_valid;

  md_req_t md_req;
  md_rsp_t md_rsp;

  tcis_muldiv u_md (
    .clk(clk),
    .rst(rst),
    .req(md_req),
    .rsp(md_rsp)
  );

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= CFG_W'(GRID_POINTS);
    end else if (psel && penable && pwrite && paddr == ADDR_POINTS) begin
      points_in_use <= pwdata[CFG_W-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_POINTS) ? {{(32-CFG_W){1'b0}}, points_in_use} : '0;

  // points actually searched
  always_comb begin
    if (points_in_use < CFG_W'(2)) n_act = CNT_W'(2);
    else if (points_in_use > CFG_W'(GRID_POINTS)) n_act = CNT_W'(GRID_POINTS);
    else n_act = CNT_W'(points_in_use);
    n_last = n_act - 1'b1;
  end

  logic accept;
  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // search probe and compare
  logic [CNT_W-1:0] half, probe;
  logic signed [31:0] rd_lm;
  logic [31:0] rd_cum;
  logic mass_pass, srch_less;
  logic [CNT_W-1:0] hi_sel;
  always_comb begin
    half = cnt >> 1;
    probe = first + half;
    rd_lm = rd_data[63:32];
    rd_cum = rd_data[31:0];
    mass_pass = (pass == P_CMIN) || (pass == P_CMAX);
    if (mass_pass) srch_less = $signed({rd_lm[31], rd_lm}) < key;
    else srch_less = $signed({1'b0, rd_cum}) < key;
    if (first < CNT_W'(1)) hi_sel = CNT_W'(1);
    else if (first > n_last) hi_sel = n_last;
    else hi_sel = first;
  end

  // range clamp
  logic signed [31:0] lo_c, hi_c;
  always_comb begin
    lo_c = (rmin > lm0) ? rmin : lm0;
    hi_c = (rmax < lmn) ? rmax : lmn;
  end

  // end-point tests of a pass
  logic pt_low, pt_high;
  logic signed [33:0] pt_low_val, pt_high_val;
  always_comb begin
    if (mass_pass) begin
      pt_low = key <= $signed({lm0[31], lm0});
      pt_high = key >= $signed({lmn[31], lmn});
      pt_low_val = $signed({2'b0, c0});
      pt_high_val = $signed({2'b0, cn});
    end else begin
      pt_low = key <= $signed({1'b0, c0});
      pt_high = key >= $signed({1'b0, cn});
      pt_low_val = {{2{lm0[31]}}, lm0};
      pt_high_val = {{2{lmn[31]}}, lmn};
    end
  end

  // interpolation operands
  logic signed [33:0] va, vb, num, den, numc, diff;
  logic up;
  logic signed [31:0] pa_lm, pb_lm;
  always_comb begin
    pa_lm = pa[63:32];
    pb_lm = pb[63:32];
    case (pass)
      P_CMIN, P_CMAX: begin
        va = $signed({2'b0, pa[31:0]});
        vb = $signed({2'b0, pb[31:0]});
        num = {key[32], key} - {{2{pa_lm[31]}}, pa_lm};
        den = {{2{pb_lm[31]}}, pb_lm} - {{2{pa_lm[31]}}, pa_lm};
      end
      P_BLEND: begin
        va = cmin;
        vb = cmax;
        num = $signed({2'b0, udraw});
        den = 34'sh1_0000_0000;
      end
      default: begin
        va = {{2{pa_lm[31]}}, pa_lm};
        vb = {{2{pb_lm[31]}}, pb_lm};
        num = {key[32], key} - $signed({2'b0, pa[31:0]});
        den = $signed({2'b0, pb[31:0]}) - $signed({2'b0, pa[31:0]});
      end
    endcase
    up = vb >= va;
    diff = up ? vb - va : va - vb;
    if (num < 0) numc = '0;
    else if (num > den) numc = den;
    else numc = num;
  end

  logic signed [33:0] lerp_val;
  assign lerp_val = up_r ? va_r + $signed({1'b0, md_rsp.q}) : va_r - $signed({1'b0, md_rsp.q});

  logic slot_free;
  assign slot_free = !out_valid || rsp.ready;

  // next state, memory address and unit request
  always_comb begin
    state_next = state;
    rd_addr = probe[IDX_W-1:0];
    md_req.start = 1'b0;
    md_req.a = diff[MD_W-1:0];
    md_req.b = numc[MD_W-1:0];
    md_req.d = den[MD_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.action == ACT_SAMPLE || req.action == ACT_PROB) state_next = S_END_LO;
          else state_next = S_DONE;
        end
      end
      S_END_LO: begin
        rd_addr = '0;
        state_next = S_END_HI;
      end
      S_END_HI: begin
        rd_addr = n_last[IDX_W-1:0];
        state_next = S_END_CAP;
      end
      S_END_CAP: state_next = S_CLAMP;
      S_CLAMP: begin
        if (!(rmax > rmin) || !(hi_c > lo_c)) state_next = S_DONE;
        else state_next = S_PT_START;
      end
      S_PT_START: begin
        if (pt_low || pt_high) state_next = S_PASS_END;
        else state_next = S_SRCH;
      end
      S_SRCH: begin
        if (cnt == '0) state_next = S_FETCH_LO;
        else state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: state_next = S_SRCH;
      S_FETCH_LO: begin
        rd_addr = hi_idx - 1'b1;
        state_next = S_FETCH_HI;
      end
      S_FETCH_HI: begin
        rd_addr = hi_idx;
        state_next = S_FETCH_CAP;
      end
      S_FETCH_CAP: state_next = S_LERP_SET;
      S_LERP_SET: begin
        if (den <= 0) begin
          state_next = S_PASS_END;
        end else begin
          md_req.start = 1'b1;
          state_next = S_LERP_RUN;
        end
      end
      S_LERP_RUN: begin
        if (md_rsp.done) state_next = S_PASS_END;
      end
      S_PASS_END: begin
        case (pass)
          P_CMIN, P_BLEND: state_next = S_PT_START;
          P_CMAX: state_next = (act == ACT_PROB) ? S_DONE : S_LERP_SET;
          default: state_next = S_DONE;
        endcase
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (accept && req.action == ACT_LOAD) begin
      mem[req.point_index] <= {req.point_log_mass, req.point_cumulative};
    end
    rd_data <= mem[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act <= req.action;
        rmin <= req.min_log_mass;
        rmax <= req.max_log_mass;
        udraw <= req.uniform_draw;
        res_sample <= '0;
        res_prob <= '0;
        if (req.action == ACT_LOAD || req.action == ACT_SAMPLE || req.action == ACT_PROB) begin
          res_status <= ST_OK;
        end else begin
          res_status <= ST_BAD;
        end
      end
      S_END_HI: begin
        lm0 <= rd_lm;
        c0 <= rd_cum;
      end
      S_END_CAP: begin
        lmn <= rd_lm;
        cn <= rd_cum;
      end
      S_CLAMP: begin
        if (!(rmax > rmin)) res_status <= ST_EMPTY;
        else if (!(hi_c > lo_c)) res_status <= ST_OUTSIDE;
        key <= {lo_c[31], lo_c};
        hi_x <= hi_c;
        pass <= P_CMIN;
      end
      S_PT_START: begin
        if (pt_low) val <= pt_low_val;
        else if (pt_high) val <= pt_high_val;
        first <= '0;
        cnt <= n_act;
      end
      S_SRCH: begin
        hi_idx <= hi_sel[IDX_W-1:0];
      end
      S_SRCH_CMP: begin
        if (srch_less) begin
          first <= probe + 1'b1;
          cnt <= cnt - half - 1'b1;
        end else begin
          cnt <= half;
        end
      end
      S_FETCH_HI: pa <= rd_data;
      S_FETCH_CAP: pb <= rd_data;
      S_LERP_SET: begin
        va_r <= va;
        up_r <= up;
        if (den <= 0) val <= va;
      end
      S_LERP_RUN: begin
        if (md_rsp.done) val <= lerp_val;
      end
      S_PASS_END: begin
        case (pass)
          P_CMIN: begin
            cmin <= val;
            pass <= P_CMAX;
            key <= {hi_x[31], hi_x};
          end
          P_CMAX: begin
            cmax <= val;
            pass <= P_BLEND;
            // only a probability item reports the difference
            if (act == ACT_PROB && val > cmin) res_prob <= 32'(val - cmin);
          end
          P_BLEND: begin
            key <= val[32:0];
            pass <= P_INV;
          end
          default: res_sample <= val[31:0];
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (state == S_DONE && slot_free) begin
      rsp.sampled_log_mass <= res_sample;
      rsp.range_probability <= res_prob;
      rsp.status <= res_status;
    end
  end
  assign rsp.valid = out_valid;

  // checks
  logic [CNT_W:0] srch_span;
  logic srch_in_range, done_issue;
  assign srch_span = {1'b0, first} + {1'b0, cnt};
  assign srch_in_range = srch_span <= {1'b0, n_act};
  assign done_issue = (state == S_DONE) && slot_free;

  `TCIS_ASSERT_IMPLIES(a_srch_window, clk, rst, state == S_SRCH, srch_in_range)
  `TCIS_ASSERT_NEXT(a_srch_shrinks, clk, rst, state == S_SRCH_CMP, cnt < $past(cnt))
  `TCIS_ASSERT_IMPLIES(a_unit_owned, clk, rst, md_rsp.busy, state == S_LERP_RUN)
  `TCIS_ASSERT_NEXT(a_result_shown, clk, rst, done_issue, out_valid)

endmodule
`default_nettype wire
